[hdl/nvqp_pkg.sv]
// nvqp_pkg: types, constants and register codes shared by the NVMe I/O queue pair engine.
// No dependencies; used by nvqp_step, nvme_io_queue_pair_engine and nvqp_checker.
package nvqp_pkg;

    // Ring and transfer geometry
    localparam int MAX_ENTRIES  = 64;
    localparam int SECTOR_BYTES = 512;   // power of two
    localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
    localparam int PAGE_BYTES   = 4096;  // power of two
    localparam int PAGE_BITS    = $clog2(PAGE_BYTES);
    localparam int BYTES_W      = 16 + SECTOR_SHIFT;  // block count times sector size
    localparam int SPAN_W       = PAGE_BITS + 1;      // holds 0 .. PAGE_BYTES
    localparam int TOTAL_W      = SPAN_W + 1;         // first span plus remainder, rounded

    localparam logic [18:0] DOORBELL_BASE = 19'h0_1000;

    // Configuration register map (word index = paddr[4:2])
    localparam int          APB_AW       = 5;
    localparam logic [2:0]  REG_NSID     = 3'd0;
    localparam logic [2:0]  REG_QENTRIES = 3'd1;
    localparam logic [2:0]  REG_DBSTRIDE = 3'd2;
    localparam logic [2:0]  REG_QNUM     = 3'd3;
    localparam logic [2:0]  REG_POLLLIM  = 3'd4;

    localparam logic [31:0] RST_NSID     = 32'd1;
    localparam logic [6:0]  RST_QENTRIES = 7'd64;
    localparam logic [3:0]  RST_DBSTRIDE = 4'd0;
    localparam logic [3:0]  RST_QNUM     = 4'd1;
    localparam logic [19:0] RST_POLLLIM  = 20'd1000000;

    // Request type codes
    localparam logic REQ_SUBMIT   = 1'b0;
    localparam logic REQ_COMPLETE = 1'b1;

    // Doorbell selectors
    localparam logic DB_TAIL = 1'b0;
    localparam logic DB_HEAD = 1'b1;

    typedef enum logic [2:0] {
        KIND_POSTED    = 3'd0,
        KIND_NOT_READY = 3'd1,
        KIND_DONE_OK   = 3'd2,
        KIND_DONE_ERR  = 3'd3,
        KIND_TIMEOUT   = 3'd4
    } t_kind;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  command_opcode;
        logic [63:0] start_block;
        logic [15:0] block_count;
        logic [63:0] buffer_address;
        logic [31:0] completion_word;
    } t_req;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [5:0]  ring_slot;
        logic [7:0]  opcode_out;
        logic [31:0] entry_namespace;
        logic [63:0] prp_first;
        logic [63:0] prp_second;
        logic [63:0] lba_out;
        logic [15:0] blocks_minus_one;
        logic [18:0] doorbell_offset;
        logic [5:0]  doorbell_value;
        logic [14:0] status_code;
    } t_res;

    typedef struct packed {
        logic [31:0] namespace_id;
        logic [6:0]  queue_entries;
        logic [3:0]  db_stride_exp;
        logic [3:0]  queue_number;
        logic [19:0] poll_limit;
    } t_cfg;

    typedef struct packed {
        logic [5:0]  submit_tail;
        logic [5:0]  complete_head;
        logic        expected_phase;
        logic [19:0] poll_count;
    } t_qstate;

endpackage

[hdl/nvqp_step.sv]
// nvqp_step: combinational work for one transaction - builds the submission entry or
// evaluates the completion word, and gives the next queue state. Depends on nvqp_pkg.
module nvqp_step
    import nvqp_pkg::*;
(
    input  t_req    i_req,
    input  t_cfg    i_cfg,
    input  t_qstate i_state,
    output t_res    o_res,
    output t_qstate o_state
);

    // {wrapped, next pointer}
    function automatic logic [6:0] ring_advance(input logic [5:0] ptr, input logic [6:0] entries);
        logic [6:0] size;
        logic [6:0] nxt;
        size = (entries > 7'(MAX_ENTRIES)) ? 7'(MAX_ENTRIES) : entries;
        nxt  = {1'b0, ptr} + 7'd1;
        if (nxt >= size) begin
            return {1'b1, 6'd0};
        end
        return {1'b0, nxt[5:0]};
    endfunction

    function automatic logic [18:0] doorbell_at(input logic [3:0] stride, input logic [3:0] qnum,
                                                input logic which);
        logic [4:0] idx;
        logic [4:0] sh;
        idx = {qnum, which};
        sh  = {1'b0, stride} + 5'd2;
        return DOORBELL_BASE + (19'(idx) << sh);
    endfunction

    logic [15:0]        nlb;
    logic [BYTES_W-1:0] bytes_len;
    logic [SPAN_W-1:0]  span_raw;
    logic [SPAN_W-1:0]  lead_span;
    logic [BYTES_W-1:0] remain_raw;
    logic [SPAN_W-1:0]  remain;
    logic [TOTAL_W-1:0] total_rnd;
    logic               spill;
    logic [15:0]        nlb_adj;
    logic [63:0]        prp2;
    logic [6:0]         tail_adv;
    logic [6:0]         head_adv;
    logic               phase;
    logic [14:0]        status;
    logic [20:0]        seen;

    // Submission: PRP split and block count trim
    always_comb begin
        nlb        = (i_req.block_count == 16'd0) ? 16'd1 : i_req.block_count;
        bytes_len  = BYTES_W'(nlb) << SECTOR_SHIFT;
        span_raw   = SPAN_W'(PAGE_BYTES) - SPAN_W'(i_req.buffer_address[PAGE_BITS-1:0]);
        lead_span  = (BYTES_W'(span_raw) > bytes_len) ? bytes_len[SPAN_W-1:0] : span_raw;
        spill      = bytes_len > BYTES_W'(lead_span);
        remain_raw = bytes_len - BYTES_W'(lead_span);
        remain     = (remain_raw > BYTES_W'(PAGE_BYTES)) ? SPAN_W'(PAGE_BYTES)
                                                         : remain_raw[SPAN_W-1:0];
        total_rnd  = TOTAL_W'(lead_span) + TOTAL_W'(remain) + TOTAL_W'(SECTOR_BYTES - 1);
        nlb_adj    = spill ? 16'(total_rnd >> SECTOR_SHIFT) : nlb;
        prp2       = spill ? (i_req.buffer_address + 64'(lead_span)) : 64'd0;
    end

    assign tail_adv = ring_advance(i_state.submit_tail, i_cfg.queue_entries);
    assign head_adv = ring_advance(i_state.complete_head, i_cfg.queue_entries);
    assign phase    = i_req.completion_word[16];
    assign status   = i_req.completion_word[31:17];
    assign seen     = {1'b0, i_state.poll_count} + 21'd1;

    always_comb begin
        o_res   = '0;
        o_state = i_state;
        if (i_req.req_type == REQ_SUBMIT) begin
            o_res.result_kind      = KIND_POSTED;
            o_res.ring_slot        = i_state.submit_tail;
            o_res.opcode_out       = i_req.command_opcode;
            o_res.entry_namespace  = i_cfg.namespace_id;
            o_res.prp_first        = i_req.buffer_address;
            o_res.prp_second       = prp2;
            o_res.lba_out          = i_req.start_block;
            o_res.blocks_minus_one = nlb_adj - 16'd1;
            o_res.doorbell_offset  = doorbell_at(i_cfg.db_stride_exp, i_cfg.queue_number,
                                                 DB_TAIL);
            o_res.doorbell_value   = tail_adv[5:0];
            o_state.submit_tail    = tail_adv[5:0];
            o_state.poll_count     = '0;
        end else if (phase != i_state.expected_phase) begin
            if (seen >= 21'(i_cfg.poll_limit)) begin
                o_res.result_kind  = KIND_TIMEOUT;
                o_state.poll_count = '0;
            end else begin
                o_res.result_kind  = KIND_NOT_READY;
                o_state.poll_count = seen[19:0];
            end
        end else begin
            o_res.result_kind      = (status == 15'd0) ? KIND_DONE_OK : KIND_DONE_ERR;
            o_res.doorbell_offset  = doorbell_at(i_cfg.db_stride_exp, i_cfg.queue_number,
                                                 DB_HEAD);
            o_res.doorbell_value   = head_adv[5:0];
            o_res.status_code      = status;
            o_state.complete_head  = head_adv[5:0];
            o_state.expected_phase = i_state.expected_phase ^ head_adv[6];
            o_state.poll_count     = '0;
        end
    end

endmodule

[hdl/nvme_io_queue_pair_engine.sv]
// nvme_io_queue_pair_engine: top level of the host-side NVMe I/O queue pair engine.
// Depends on nvqp_pkg and nvqp_step.

// One transaction on the request channel gives exactly one transaction on the result
// channel, in order. Throughput is one request per clock unless a result is held by
// i_ready low: a request is captured in an input register, evaluated by nvqp_step (PRP
// split, block count trim, ring pointer and phase update, doorbell offset) and written
// to the result register, which drives o_valid, once that register is empty or being
// drained. The queue state (submission tail, completion head, expected phase, poll
// count) updates at the same edge that loads the result register, so back-to-back
// requests see the state left by their predecessor.
// o_ready stays high while the result register is empty or being drained this cycle;
// it drops only when a result is held by i_ready low and a request already waits in the
// input register. Configuration lives behind an APB-style port, one 32-bit word per
// register at byte offset 4*index: namespace id, queue entries, doorbell stride, queue
// number, poll limit. Writes complete in the access phase (pready tied high) and are
// meant to be made while the engine is idle. Reads return the stored register value.
module nvme_io_queue_pair_engine
    import nvqp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_valid,
    output logic              o_ready,
    input  t_req              i_req,
    // result channel
    output logic              o_valid,
    input  logic              i_ready,
    output t_res              o_res,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg    r_cfg;
    t_qstate r_state;
    t_qstate n_state;
    logic    r_in_valid;
    logic    n_in_valid;
    t_req    r_in;
    logic    r_out_valid;
    logic    n_out_valid;
    t_res    r_out;
    t_res    n_out;

    logic    w_move;
    logic    w_take;
    logic    w_cfg_wr;
    logic [2:0] w_reg_idx;

    // ---------------------------------------------------------------- config port
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[APB_AW-1:2];
    assign w_cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.namespace_id    <= RST_NSID;
            r_cfg.queue_entries   <= RST_QENTRIES;
            r_cfg.db_stride_exp   <= RST_DBSTRIDE;
            r_cfg.queue_number    <= RST_QNUM;
            r_cfg.poll_limit      <= RST_POLLLIM;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_NSID:     r_cfg.namespace_id    <= pwdata;
                REG_QENTRIES: r_cfg.queue_entries   <= pwdata[6:0];
                REG_DBSTRIDE: r_cfg.db_stride_exp   <= pwdata[3:0];
                REG_QNUM:     r_cfg.queue_number    <= pwdata[3:0];
                REG_POLLLIM:  r_cfg.poll_limit      <= pwdata[19:0];
                default: ;  // unmapped: ignored
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_NSID:     prdata = r_cfg.namespace_id;
            REG_QENTRIES: prdata = 32'(r_cfg.queue_entries);
            REG_DBSTRIDE: prdata = 32'(r_cfg.db_stride_exp);
            REG_QNUM:     prdata = 32'(r_cfg.queue_number);
            REG_POLLLIM:  prdata = 32'(r_cfg.poll_limit);
            default:      prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- datapath
    // input register -> nvqp_step -> result register
    assign w_move  = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_move;
    assign w_take  = i_valid && o_ready;

    nvqp_step u_step (
        .i_req   (r_in),
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .o_res   (n_out),
        .o_state (n_state)
    );

    always_comb begin
        if (w_take) begin
            n_in_valid = 1'b1;
        end else if (w_move) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end

        if (w_move) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid             <= 1'b0;
            r_out_valid            <= 1'b0;
            r_state.submit_tail    <= '0;
            r_state.complete_head  <= '0;
            r_state.expected_phase <= 1'b1;
            r_state.poll_count     <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (w_move) begin
                r_state <= n_state;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in <= i_req;
        end
        if (w_move) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

[hdl/nvqp_checker.sv]
// nvqp_checker: port-level assertions for nvme_io_queue_pair_engine, bound to the top level.
// Depends on nvqp_pkg.
module nvqp_checker
    import nvqp_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_ready,
    input t_res o_res,
    input logic pready
);

    // no result straight out of reset
    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_res))
        else $error("stalled result changed");

    // result kind is one of the defined codes
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_res.result_kind <= KIND_TIMEOUT)
        else $error("undefined result kind");

    // polls that fail ring no doorbell and carry no entry
    a_poll_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_res.result_kind == KIND_NOT_READY || o_res.result_kind == KIND_TIMEOUT)
        |-> o_res.doorbell_offset == '0 && o_res.doorbell_value == '0
            && o_res.status_code == '0 && o_res.prp_first == '0 && pready)
        else $error("failed poll carries doorbell or entry data");

endmodule

bind nvme_io_queue_pair_engine nvqp_checker u_nvqp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_res   (o_res),
    .pready  (pready)
);

[tb/tb.sv]
// tb: self-checking bench for nvme_io_queue_pair_engine (submission build, completion polling).
// Depends on nvqp_pkg and the engine RTL; a behavioural mirror of the queue pair
// predicts every result transaction, which is compared field by field in arrival order.
module tb;
    import nvqp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One stimulus row: either a register write or a request, with an optional
    // hand-typed result that replaces the mirror's prediction.
    typedef struct {
        bit          is_reg;
        logic [2:0]  reg_idx;
        logic [31:0] reg_val;
        t_req        req;
        bit          has_golden;
        t_res        golden;
    } t_row;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    t_req              i_req   = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    t_res              o_res;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    // Mirror of the engine: register file and queue pair pointers
    t_cfg    qp_regs;
    t_qstate qp_state;

    t_res    pending_results[$];
    t_row    stim_rows[$];

    int      mismatches   = 0;
    int      results_seen = 0;
    int      kind_seen[5] = '{default: 0};
    int      reg_sets     = 0;
    int      src_idle_pct = 33;
    int      snk_idle_pct = 75;
    int      hold_request = 0;
    int      hold_left    = 0;

    nvme_io_queue_pair_engine i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (o_res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Queue pair mirror
    // ------------------------------------------------------------------

    // Advance a ring pointer; ring size capped at MAX_ENTRIES, sizes 0 and 1 pin it at 0
    function automatic logic [5:0] ring_step(input logic [5:0] ptr, output bit wrapped);
        int unsigned size;
        int unsigned nxt;
        size = qp_regs.queue_entries;
        if (size > MAX_ENTRIES) size = MAX_ENTRIES;
        nxt = ptr + 1;
        wrapped = 1'b0;
        if (nxt >= size) begin
            nxt = 0;
            wrapped = 1'b1;
        end
        return nxt[5:0];
    endfunction

    // Tail doorbell sits at slot 2*qid, head doorbell at 2*qid+1, 4<<stride bytes apart
    function automatic logic [18:0] doorbell_addr(input logic which);
        logic [63:0] unit;
        logic [63:0] idx;
        logic [63:0] full;
        unit = 64'd4 << qp_regs.db_stride_exp;
        idx  = 2 * qp_regs.queue_number + which;
        full = DOORBELL_BASE + idx * unit;
        return full[18:0];
    endfunction

    // Work out the result of one accepted request and move the mirror state on
    function automatic t_res predict_result(input t_req r);
        t_res        res;
        int unsigned nlb;
        int unsigned bytes;
        int unsigned span;
        int unsigned rest;
        int unsigned seen;
        bit          wrapped;
        logic [14:0] status;
        res = '0;
        if (r.req_type == REQ_SUBMIT) begin
            nlb   = (r.block_count == 16'd0) ? 1 : r.block_count;
            bytes = nlb * SECTOR_BYTES;
            span  = PAGE_BYTES - r.buffer_address[PAGE_BITS-1:0];
            if (span > bytes) span = bytes;
            // spill into a second page: PRP2 covers at most one further page
            if (bytes > span) begin
                rest = bytes - span;
                if (rest > PAGE_BYTES) rest = PAGE_BYTES;
                res.prp_second = r.buffer_address + span;
                nlb = (span + rest + SECTOR_BYTES - 1) / SECTOR_BYTES;
            end
            res.result_kind      = KIND_POSTED;
            res.ring_slot        = qp_state.submit_tail;
            res.opcode_out       = r.command_opcode;
            res.entry_namespace  = qp_regs.namespace_id;
            res.prp_first        = r.buffer_address;
            res.lba_out          = r.start_block;
            res.blocks_minus_one = 16'(nlb - 1);
            qp_state.submit_tail = ring_step(qp_state.submit_tail, wrapped);
            res.doorbell_offset  = doorbell_addr(DB_TAIL);
            res.doorbell_value   = qp_state.submit_tail;
            qp_state.poll_count  = '0;
        end else if (r.completion_word[16] != qp_state.expected_phase) begin
            seen = qp_state.poll_count + 1;
            if (seen >= qp_regs.poll_limit) begin
                qp_state.poll_count = '0;
                res.result_kind     = KIND_TIMEOUT;
            end else begin
                qp_state.poll_count = seen[19:0];
                res.result_kind     = KIND_NOT_READY;
            end
        end else begin
            status = r.completion_word[31:17];
            qp_state.complete_head = ring_step(qp_state.complete_head, wrapped);
            if (wrapped) qp_state.expected_phase = ~qp_state.expected_phase;
            qp_state.poll_count = '0;
            res.result_kind     = (status == 15'd0) ? KIND_DONE_OK : KIND_DONE_ERR;
            res.doorbell_offset = doorbell_addr(DB_HEAD);
            res.doorbell_value  = qp_state.complete_head;
            res.status_code     = status;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus rows
    // ------------------------------------------------------------------

    function automatic t_row sub_row(input logic [7:0] op, input logic [63:0] lba,
                                     input logic [15:0] cnt, input logic [63:0] addr);
        t_row row;
        row = '{default: '0};
        row.req.req_type       = REQ_SUBMIT;
        row.req.command_opcode = op;
        row.req.start_block    = lba;
        row.req.block_count    = cnt;
        row.req.buffer_address = addr;
        row.req.completion_word = 32'hDEAD_BEEF;
        return row;
    endfunction

    function automatic t_row cpl_row(input logic [31:0] word);
        t_row row;
        row = '{default: '0};
        row.req.req_type        = REQ_COMPLETE;
        row.req.completion_word = word;
        row.req.command_opcode  = 8'hA5;
        row.req.block_count     = 16'h00F0;
        return row;
    endfunction

    function automatic t_row reg_row(input logic [2:0] idx, input logic [31:0] val);
        t_row row;
        row = '{default: '0};
        row.is_reg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic t_row golden(input t_row row, input t_res res);
        row.has_golden = 1'b1;
        row.golden     = res;
        return row;
    endfunction

    function automatic t_res posted_res(input logic [5:0] slot, input logic [7:0] op,
                                        input logic [31:0] ns, input logic [63:0] prp1,
                                        input logic [63:0] prp2, input logic [63:0] lba,
                                        input logic [15:0] bm1, input logic [18:0] dboff,
                                        input logic [5:0] dbval);
        t_res res;
        res = '0;
        res.result_kind      = KIND_POSTED;
        res.ring_slot        = slot;
        res.opcode_out       = op;
        res.entry_namespace  = ns;
        res.prp_first        = prp1;
        res.prp_second       = prp2;
        res.lba_out          = lba;
        res.blocks_minus_one = bm1;
        res.doorbell_offset  = dboff;
        res.doorbell_value   = dbval;
        return res;
    endfunction

    function automatic t_res poll_res(input t_kind kind, input logic [18:0] dboff,
                                      input logic [5:0] dbval, input logic [14:0] status);
        t_res res;
        res = '0;
        res.result_kind     = kind;
        res.doorbell_offset = dboff;
        res.doorbell_value  = dbval;
        res.status_code     = status;
        return res;
    endfunction

    // Random request: mostly a host that submits and then polls with the right phase,
    // plus stale polls, odd block counts and buffers near page edges.
    function automatic t_req rand_req();
        t_req r;
        r.req_type        = ($urandom_range(99) < 40) ? REQ_SUBMIT : REQ_COMPLETE;
        r.command_opcode  = 8'($urandom);
        r.start_block     = {$urandom, $urandom};
        r.buffer_address  = {$urandom, $urandom};
        r.completion_word = $urandom;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: r.block_count = 16'($urandom_range(1, 16));
            6, 7:             r.block_count = 16'($urandom_range(17, 80));
            8:                r.block_count = 16'($urandom);
            default:          r.block_count = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        endcase
        case ($urandom_range(3))
            0: r.buffer_address[11:0] = '0;
            1: r.buffer_address[11:0] = 12'(12'hFFF - $urandom_range(600));
            default: ;
        endcase
        if ($urandom_range(99) < 70) begin
            r.completion_word[16] = qp_state.expected_phase;
            if ($urandom_range(1)) r.completion_word[31:17] = '0;
        end else begin
            r.completion_word[16] = ~qp_state.expected_phase;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers (each called just after a rising edge, returns at a rising edge)
    // ------------------------------------------------------------------

    // Offer one request transaction; prediction is taken at the accepting edge
    task automatic send_req(input t_req r, input bit use_golden, input t_res gold);
        t_res pred;
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (!o_ready);
        pred = predict_result(r);
        pending_results.push_back(use_golden ? gold : pred);
    endtask

    // Stop offering and wait for every outstanding result transaction
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Register write (setup + access), then read the register back; the port is left
    // idle at the end so back-to-back calls never drive the port twice in a step
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        logic [31:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        want = '0;
        case (idx)
            REG_NSID:     begin qp_regs.namespace_id    = val;        want = val;         end
            REG_QENTRIES: begin qp_regs.queue_entries   = val[6:0];   want[6:0]  = val[6:0];  end
            REG_DBSTRIDE: begin qp_regs.db_stride_exp   = val[3:0];   want[3:0]  = val[3:0];  end
            REG_QNUM:     begin qp_regs.queue_number    = val[3:0];   want[3:0]  = val[3:0];  end
            REG_POLLLIM:  begin qp_regs.poll_limit      = val[19:0];  want[19:0] = val[19:0]; end
            default: ;
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (prdata !== want) begin
            $display("%0t ns: readback of register %0d, expected %0h, got %0h",
                     $time, idx, want, prdata);
            mismatches++;
        end
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [31:0] nsid, input logic [31:0] qe,
                              input logic [31:0] stride, input logic [31:0] qn,
                              input logic [31:0] limit);
        reg_write(REG_NSID, nsid);
        reg_write(REG_QENTRIES, qe);
        reg_write(REG_DBSTRIDE, stride);
        reg_write(REG_QNUM, qn);
        reg_write(REG_POLLLIM, limit);
        reg_sets++;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, long hold-offs on request, checking
    // ------------------------------------------------------------------

    task automatic cmp_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result(input t_res got);
        t_res want;
        if (pending_results.size() == 0) begin
            $display("%0t ns: unexpected result transaction, expected none, got %0h",
                     $time, got);
            mismatches++;
        end else begin
            want = pending_results.pop_front();
            cmp_field("result_kind",      want.result_kind,      got.result_kind);
            cmp_field("ring_slot",        want.ring_slot,        got.ring_slot);
            cmp_field("opcode_out",       want.opcode_out,       got.opcode_out);
            cmp_field("entry_namespace",  want.entry_namespace,  got.entry_namespace);
            cmp_field("prp_first",        want.prp_first,        got.prp_first);
            cmp_field("prp_second",       want.prp_second,       got.prp_second);
            cmp_field("lba_out",          want.lba_out,          got.lba_out);
            cmp_field("blocks_minus_one", want.blocks_minus_one, got.blocks_minus_one);
            cmp_field("doorbell_offset",  want.doorbell_offset,  got.doorbell_offset);
            cmp_field("doorbell_value",   want.doorbell_value,   got.doorbell_value);
            cmp_field("status_code",      want.status_code,      got.status_code);
        end
        results_seen++;
        if (got.result_kind <= KIND_TIMEOUT) kind_seen[got.result_kind]++;
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) check_result(o_res);
            // a requested hold-off is counted out here, independent of the sender
            if (hold_left == 0 && hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else begin
                i_ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        qp_regs  = '{namespace_id: RST_NSID, queue_entries: RST_QENTRIES,
                     db_stride_exp: RST_DBSTRIDE, queue_number: RST_QNUM,
                     poll_limit: RST_POLLLIM};
        qp_state = '{submit_tail: '0, complete_head: '0, expected_phase: 1'b1,
                     poll_count: '0};

        // Directed part. Reset values first: tail doorbell 0x1008, head doorbell 0x100c.
        stim_rows.push_back(golden(sub_row(8'h00, 64'd0, 16'd1, 64'd0),
            posted_res(6'd0, 8'h00, 32'd1, 64'd0, 64'd0, 64'd0, 16'd0, 19'h01008, 6'd1)));
        // zero count counts as one block; one byte left in the page, PRP2 wraps to 0
        stim_rows.push_back(golden(sub_row(8'hFF, '1, 16'd0, '1),
            posted_res(6'd1, 8'hFF, 32'd1, '1, 64'd0, '1, 16'd0, 19'h01008, 6'd2)));
        // largest count trimmed to two aligned pages
        stim_rows.push_back(golden(sub_row(8'h02, 64'h8000_0000_0000_0000, 16'hFFFF,
                                           64'h0000_0001_0000_0000),
            posted_res(6'd2, 8'h02, 32'd1, 64'h0000_0001_0000_0000, 64'h0000_0001_0000_1000,
                       64'h8000_0000_0000_0000, 16'd15, 19'h01008, 6'd3)));
        // exactly one page: no PRP2
        stim_rows.push_back(golden(sub_row(8'h01, 64'd100, 16'd8, 64'h1000),
            posted_res(6'd3, 8'h01, 32'd1, 64'h1000, 64'd0, 64'd100, 16'd7, 19'h01008, 6'd4)));
        stim_rows.push_back(sub_row(8'h02, 64'h5555_AAAA_5555_AAAA, 16'd9, 64'hDEAD_B800));
        stim_rows.push_back(golden(cpl_row(32'h0000_0000),
            poll_res(KIND_NOT_READY, 19'd0, 6'd0, 15'd0)));
        stim_rows.push_back(golden(cpl_row(32'h0001_0000),
            poll_res(KIND_DONE_OK, 19'h0100C, 6'd1, 15'd0)));
        stim_rows.push_back(golden(cpl_row(32'hFFFF_FFFF),
            poll_res(KIND_DONE_ERR, 19'h0100C, 6'd2, 15'h7FFF)));
        // two-entry ring, widest doorbell spacing (offset overflows 19 bits), limit of one
        stim_rows.push_back(reg_row(REG_NSID, 32'hFFFF_FFFF));
        stim_rows.push_back(reg_row(REG_QENTRIES, 32'd2));
        stim_rows.push_back(reg_row(REG_DBSTRIDE, 32'd15));
        stim_rows.push_back(reg_row(REG_QNUM, 32'd15));
        stim_rows.push_back(reg_row(REG_POLLLIM, 32'd1));
        stim_rows.push_back(sub_row(8'h80, 64'h0123_4567_89AB_CDEF, 16'd3,
                                    64'hFFFF_FFFF_FFFF_F000));
        stim_rows.push_back(sub_row(8'h7F, 64'hFEDC_BA98_7654_3210, 16'd40,
                                    64'h0123_4567_89AB_CDEF));
        stim_rows.push_back(golden(cpl_row(32'h0000_FFFF),
            poll_res(KIND_TIMEOUT, 19'd0, 6'd0, 15'd0)));
        stim_rows.push_back(cpl_row(32'h0003_0000));  // head wraps, phase flips
        stim_rows.push_back(golden(cpl_row(32'hFFFF_FFFF),
            poll_res(KIND_TIMEOUT, 19'd0, 6'd0, 15'd0)));
        stim_rows.push_back(cpl_row(32'h0000_0000));
        // ring size 0 and limit 0 behave as pinned pointer and limit one; queue id 0
        stim_rows.push_back(reg_row(REG_QENTRIES, 32'd0));
        stim_rows.push_back(reg_row(REG_POLLLIM, 32'd0));
        stim_rows.push_back(reg_row(REG_DBSTRIDE, 32'd0));
        stim_rows.push_back(reg_row(REG_QNUM, 32'd0));
        stim_rows.push_back(sub_row(8'h11, 64'd7, 16'd2, 64'h0000_0000_0000_0E00));
        stim_rows.push_back(golden(cpl_row(32'h0001_0000),
            poll_res(KIND_TIMEOUT, 19'd0, 6'd0, 15'd0)));
        stim_rows.push_back(reg_row(REG_QENTRIES, 32'd1));
        stim_rows.push_back(sub_row(8'h22, 64'd8, 16'd4, 64'h0000_0000_0000_0010));
        stim_rows.push_back(cpl_row(32'h0000_0000));
        // oversized ring (capped), poll limit of three
        stim_rows.push_back(reg_row(REG_QENTRIES, 32'd127));
        stim_rows.push_back(reg_row(REG_POLLLIM, 32'd3));
        stim_rows.push_back(golden(cpl_row(32'h0000_0000),
            poll_res(KIND_NOT_READY, 19'd0, 6'd0, 15'd0)));
        stim_rows.push_back(golden(cpl_row(32'hFFFE_FFFF),
            poll_res(KIND_NOT_READY, 19'd0, 6'd0, 15'd0)));
        stim_rows.push_back(golden(cpl_row(32'h1234_0000),
            poll_res(KIND_TIMEOUT, 19'd0, 6'd0, 15'd0)));
        stim_rows.push_back(sub_row(8'h01, 64'hFFFF_FFFF_0000_0000, 16'd33,
                                    64'h0000_7FFF_FFFF_FE00));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[n]) begin
            if (stim_rows[n].is_reg) begin
                wait_idle();
                reg_write(stim_rows[n].reg_idx, stim_rows[n].reg_val);
                reg_sets++;
            end else begin
                send_req(stim_rows[n].req, stim_rows[n].has_golden, stim_rows[n].golden);
            end
        end

        // Random part, three idling patterns, each under its own register set and
        // opened by a long receiver hold-off so the engine fills and stalls its input.
        for (int phase = 0; phase < 3; phase++) begin
            wait_idle();
            case (phase)
                0: begin
                    src_idle_pct = 33;
                    snk_idle_pct = 75;
                    write_regs($urandom, 32'd64, 32'd0, 32'd1, 32'd4);
                end
                1: begin
                    src_idle_pct = 75;
                    snk_idle_pct = 33;
                    // narrow registers get junk in their upper bits
                    write_regs(32'd0, 32'hFFFF_FF7F, 32'hFFFF_FFFF, 32'h0000_00FF,
                               {$urandom_range(4095), 20'd0});
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                    write_regs($urandom, $urandom_range(2, 64), $urandom_range(15),
                               $urandom_range(1, 15), 32'd2);
                end
            endcase
            hold_request = 48;
            repeat (phase == 2 ? 160 : 170) send_req(rand_req(), 1'b0, '0);
        end

        wait_idle();
        repeat (8) @(posedge i_clk);

        $display("%0d result transactions checked: %0d posted, %0d not ready, %0d done ok,",
                 results_seen, kind_seen[0], kind_seen[1], kind_seen[2]);
        $display("%0d done with error, %0d timeouts; %0d register settings applied",
                 kind_seen[3], kind_seen[4], reg_sets);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
hdl/nvqp_pkg.sv
hdl/nvqp_step.sv
hdl/nvme_io_queue_pair_engine.sv
hdl/nvqp_checker.sv
tb/tb.sv
